// ===== sv/hpack_pkg.sv =====
// Shared definitions for the HPACK header block parser: result event codes,
// representation codes, error codes and the default integer octet limit.
// No dependencies.
`timescale 1ns / 1ps

package hpack_pkg;

	localparam int HPACK_INT_OCTET_LIMIT = 5;

	localparam int EVENT_W = 4;
	localparam int REP_W   = 2;
	localparam int NUM_W   = 32;
	localparam int OCTET_W = 8;
	localparam int ERR_W   = 2;

	typedef logic [EVENT_W-1:0] event_t;
	typedef logic [REP_W-1:0]   rep_t;
	typedef logic [ERR_W-1:0]   err_t;

	localparam event_t EV_PENDING     = 4'd0;
	localparam event_t EV_INDEXED     = 4'd1;
	localparam event_t EV_NAME_INDEX  = 4'd2;
	localparam event_t EV_NAME_LENGTH = 4'd3;
	localparam event_t EV_NAME_OCTET  = 4'd4;
	localparam event_t EV_VALUE_LEN   = 4'd5;
	localparam event_t EV_VALUE_OCTET = 4'd6;
	localparam event_t EV_SIZE_UPDATE = 4'd7;
	localparam event_t EV_ERROR       = 4'd8;

	localparam rep_t REP_INDEXED     = 2'd0;
	localparam rep_t REP_INCREMENTAL = 2'd1;
	localparam rep_t REP_WITHOUT_IDX = 2'd2;
	localparam rep_t REP_NEVER_IDX   = 2'd3;

	localparam err_t ERR_NONE       = 2'd0;
	localparam err_t ERR_INDEX_ZERO = 2'd1;
	localparam err_t ERR_OVERFLOW   = 2'd2;
	localparam err_t ERR_TRUNCATED  = 2'd3;

endpackage

// ===== sv/hpack_if.sv =====
// Stream interfaces of the HPACK header block parser: raw octets in,
// decoded events out. Depends on hpack_pkg.
`timescale 1ns / 1ps

interface hpack_octet_if;
	logic                          valid;
	logic                          ready;
	logic [hpack_pkg::OCTET_W-1:0] octet;
	logic                          block_end;

	modport source (output valid, output octet, output block_end, input ready);
	modport sink   (input valid, input octet, input block_end, output ready);
endinterface

interface hpack_event_if;
	logic                          valid;
	logic                          ready;
	hpack_pkg::event_t             event_res;
	hpack_pkg::rep_t               representation;
	logic [hpack_pkg::NUM_W-1:0]   number;
	logic [hpack_pkg::OCTET_W-1:0] octet_out;
	logic                          huffman;
	logic                          field_done;
	hpack_pkg::err_t               error_code;

	modport source (output valid, output event_res, output representation, output number,
		output octet_out, output huffman, output field_done, output error_code,
		input ready);
	modport sink   (input valid, input event_res, input representation, input number,
		input octet_out, input huffman, input field_done, input error_code,
		output ready);
endinterface

// ===== sv/hpack_header_block_parser.sv =====
// HPACK header block parser, top level: one header-block octet in, one event out.
// Depends on hpack_pkg and the stream interfaces in hpack_if.sv.
`timescale 1ns / 1ps

// The parser takes one octet of an HPACK header block per transfer on ingress
// and answers every octet with exactly one event transfer on egress, in order.
// It sustains one octet per clock cycle and registers each result: the decode
// of an octet against the parse state is a single combinational pass that
// loads both the parse state and the egress result register at the same edge.
// Ingress stays ready while the result register is empty or is being drained,
// so the only thing that slows the block is backpressure on egress.
// Events: indexed field, name index, name/value length, name/value octet
// (passed through with the Huffman flag of its string), table size update and
// error. field_done marks the octet that completes a field or size update.
// Prefixed integers may span at most INT_OCTET_LIMIT octets, prefix included,
// and must fit in 32 bits; otherwise an overflow error is reported. After an
// error the rest of the block is consumed with pending events, and parsing
// restarts at the octet after block_end. Huffman decoding and table lookups
// are left to downstream logic.
module hpack_header_block_parser #(
	parameter int INT_OCTET_LIMIT = hpack_pkg::HPACK_INT_OCTET_LIMIT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hpack_octet_if.sink           ingress,
	hpack_event_if.source         egress
);
	import hpack_pkg::*;

	// Continuation count reaches INT_OCTET_LIMIT-1; shift reaches 7 per continuation.
	localparam int CC_W  = $clog2(INT_OCTET_LIMIT);
	localparam int SH_W  = $clog2(7 * (INT_OCTET_LIMIT - 1) + 1);
	localparam int TOP_W = (7 * (INT_OCTET_LIMIT - 1) > NUM_W) ?
		7 * (INT_OCTET_LIMIT - 1) : NUM_W;
	localparam int SUM_W = TOP_W + 1;

	localparam logic [2:0] PH_REP       = 3'd0;
	localparam logic [2:0] PH_IDX_CONT  = 3'd1;
	localparam logic [2:0] PH_SIZE_CONT = 3'd2;
	localparam logic [2:0] PH_LEN_FIRST = 3'd3;
	localparam logic [2:0] PH_LEN_CONT  = 3'd4;
	localparam logic [2:0] PH_STRING    = 3'd5;
	localparam logic [2:0] PH_DRAIN     = 3'd6;

	// Parse state
	logic [2:0]       phase_q, phase_d;
	rep_t             rep_q, rep_d;
	logic [NUM_W-1:0] acc_q, acc_d;
	logic [SH_W-1:0]  shift_q, shift_d;
	logic [CC_W-1:0]  cont_q, cont_d;
	logic             huf_q, huf_d;
	logic [NUM_W-1:0] remain_q, remain_d;
	logic             in_value_q, in_value_d;

	// Result register
	logic               out_valid_q;
	event_t             event_q, ev;
	rep_t               rep_out_q, rep_out;
	logic [NUM_W-1:0]   number_q, num;
	logic [OCTET_W-1:0] octet_q, oct;
	logic               huffman_q, hf;
	logic               done_q, done;
	err_t               err_q, err;

	logic               accept;
	logic [OCTET_W-1:0] b;
	logic               last;

	// Integer decode helpers
	logic [SUM_W-1:0] addend;
	logic [SUM_W-1:0] sum;
	logic             cont_ovf;
	logic [NUM_W-1:0] prefix_val;
	logic             prefix_full;
	logic             is_size;
	rep_t             kind;
	logic             fin_idx, fin_size, fin_len, go_idle;

	assign b      = ingress.octet;
	assign last   = ingress.block_end;
	assign accept = ingress.valid && ingress.ready;

	// Take a new octet whenever the result slot is free or is being drained.
	assign ingress.ready = !out_valid_q || egress.ready;

	// Continuation octet: add 7 payload bits at the current shift.
	assign addend   = SUM_W'(b[6:0]) << shift_q;
	assign sum      = SUM_W'(acc_q) + addend;
	assign cont_ovf = (cont_q >= CC_W'(INT_OCTET_LIMIT - 1)) || (|sum[SUM_W-1:NUM_W]);

	// Classify the representation octet and pick its integer prefix.
	always_comb begin
		is_size     = 1'b0;
		kind        = REP_INDEXED;
		prefix_val  = '0;
		prefix_full = 1'b0;
		if (b[7]) begin
			kind        = REP_INDEXED;
			prefix_val  = NUM_W'(b[6:0]);
			prefix_full = &b[6:0];
		end else if (b[6]) begin
			kind        = REP_INCREMENTAL;
			prefix_val  = NUM_W'(b[5:0]);
			prefix_full = &b[5:0];
		end else if (b[5]) begin
			is_size     = 1'b1;
			kind        = REP_INDEXED;
			prefix_val  = NUM_W'(b[4:0]);
			prefix_full = &b[4:0];
		end else begin
			kind        = b[4] ? REP_NEVER_IDX : REP_WITHOUT_IDX;
			prefix_val  = NUM_W'(b[3:0]);
			prefix_full = &b[3:0];
		end
	end

	// Decode one octet against the parse state.
	always_comb begin
		phase_d    = phase_q;
		rep_d      = rep_q;
		acc_d      = acc_q;
		shift_d    = shift_q;
		cont_d     = cont_q;
		huf_d      = huf_q;
		remain_d   = remain_q;
		in_value_d = in_value_q;

		ev      = EV_PENDING;
		num     = '0;
		oct     = '0;
		hf      = 1'b0;
		done    = 1'b0;
		err     = ERR_NONE;
		rep_out = REP_INDEXED;

		fin_idx  = 1'b0;
		fin_size = 1'b0;
		fin_len  = 1'b0;
		go_idle  = 1'b0;

		unique case (phase_q)
			PH_REP: begin
				huf_d      = 1'b0;
				in_value_d = 1'b0;
				rep_d      = kind;
				acc_d      = prefix_val;
				shift_d    = '0;
				cont_d     = '0;
				if (prefix_full) begin
					phase_d = is_size ? PH_SIZE_CONT : PH_IDX_CONT;
				end else begin
					fin_size = is_size;
					fin_idx  = !is_size;
				end
			end
			PH_IDX_CONT, PH_SIZE_CONT, PH_LEN_CONT: begin
				if (cont_ovf) begin
					err = ERR_OVERFLOW;
				end else begin
					acc_d   = sum[NUM_W-1:0];
					shift_d = shift_q + SH_W'(7);
					cont_d  = cont_q + CC_W'(1);
					if (!b[7]) begin
						fin_idx  = (phase_q == PH_IDX_CONT);
						fin_size = (phase_q == PH_SIZE_CONT);
						fin_len  = (phase_q == PH_LEN_CONT);
					end
				end
			end
			PH_LEN_FIRST: begin
				huf_d   = b[7];
				acc_d   = NUM_W'(b[6:0]);
				shift_d = '0;
				cont_d  = '0;
				if (&b[6:0]) begin
					phase_d = PH_LEN_CONT;
				end else begin
					fin_len = 1'b1;
				end
			end
			PH_STRING: begin
				ev       = in_value_q ? EV_VALUE_OCTET : EV_NAME_OCTET;
				oct      = b;
				hf       = huf_q;
				remain_d = remain_q - NUM_W'(1);
				if (remain_q == NUM_W'(1)) begin
					if (in_value_q) begin
						done    = 1'b1;
						go_idle = 1'b1;
					end else begin
						in_value_d = 1'b1;
						phase_d    = PH_LEN_FIRST;
					end
				end
			end
			PH_DRAIN: begin
				go_idle = last;
			end
			default: begin
				go_idle = 1'b1;
			end
		endcase

		// Index complete: indexed field, or name index of a literal.
		if (fin_idx) begin
			if (rep_d == REP_INDEXED) begin
				if (acc_d == '0) begin
					err = ERR_INDEX_ZERO;
				end else begin
					ev      = EV_INDEXED;
					num     = acc_d;
					done    = 1'b1;
					go_idle = 1'b1;
				end
			end else begin
				if (acc_d != '0) begin
					ev  = EV_NAME_INDEX;
					num = acc_d;
				end
				in_value_d = 1'b0;
				phase_d    = PH_LEN_FIRST;
			end
		end

		if (fin_size) begin
			ev      = EV_SIZE_UPDATE;
			num     = acc_d;
			done    = 1'b1;
			go_idle = 1'b1;
		end

		// String length complete: empty strings skip the octet phase.
		if (fin_len) begin
			ev  = in_value_q ? EV_VALUE_LEN : EV_NAME_LENGTH;
			num = acc_d;
			hf  = huf_d;
			if (acc_d == '0) begin
				if (in_value_q) begin
					done    = 1'b1;
					go_idle = 1'b1;
				end else begin
					in_value_d = 1'b1;
					phase_d    = PH_LEN_FIRST;
				end
			end else begin
				remain_d = acc_d;
				phase_d  = PH_STRING;
			end
		end

		if (go_idle) begin
			phase_d    = PH_REP;
			acc_d      = '0;
			shift_d    = '0;
			cont_d     = '0;
			huf_d      = 1'b0;
			remain_d   = '0;
			in_value_d = 1'b0;
		end

		rep_out = (ev == EV_SIZE_UPDATE) ? REP_INDEXED : rep_d;

		// Block ended with a field still open.
		if (err == ERR_NONE && last && phase_d != PH_REP) begin
			err = ERR_TRUNCATED;
		end

		// Any error: report it, then drop octets up to the end of the block.
		if (err != ERR_NONE) begin
			ev         = EV_ERROR;
			num        = '0;
			oct        = '0;
			hf         = 1'b0;
			done       = 1'b0;
			phase_d    = last ? PH_REP : PH_DRAIN;
			acc_d      = '0;
			shift_d    = '0;
			cont_d     = '0;
			huf_d      = 1'b0;
			remain_d   = '0;
			in_value_d = 1'b0;
		end
	end

	// Advance the parse state on every accepted octet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_REP;
			rep_q      <= REP_INDEXED;
			acc_q      <= '0;
			shift_q    <= '0;
			cont_q     <= '0;
			huf_q      <= 1'b0;
			remain_q   <= '0;
			in_value_q <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			rep_q      <= rep_d;
			acc_q      <= acc_d;
			shift_q    <= shift_d;
			cont_q     <= cont_d;
			huf_q      <= huf_d;
			remain_q   <= remain_d;
			in_value_q <= in_value_d;
		end
	end

	// Result slot valid: set by an accepted octet, cleared by an egress transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (egress.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: load with each accepted octet, hold otherwise.
	always_ff @(posedge clk) begin
		if (accept) begin
			event_q   <= ev;
			rep_out_q <= rep_out;
			number_q  <= num;
			octet_q   <= oct;
			huffman_q <= hf;
			done_q    <= done;
			err_q     <= err;
		end
	end

	assign egress.valid          = out_valid_q;
	assign egress.event_res      = event_q;
	assign egress.representation = rep_out_q;
	assign egress.number         = number_q;
	assign egress.octet_out      = octet_q;
	assign egress.huffman        = huffman_q;
	assign egress.field_done     = done_q;
	assign egress.error_code     = err_q;

endmodule

// ===== tb/sv/tb_hpack_header_block_parser.sv =====
// Self-checking testbench for hpack_header_block_parser: directed and random header
// blocks, decoded events predicted per octet and compared field by field.
// Depends on hpack_pkg, hpack_octet_if / hpack_event_if and the parser RTL.
`timescale 1ns / 1ps

module tb_hpack_header_block_parser;
	import hpack_pkg::*;

	// Parse position of the predictor, one per kind of octet the parser can expect next.
	typedef enum logic [2:0] {
		PS_REP, PS_IDX_CONT, PS_SIZE_CONT, PS_LEN_FIRST, PS_LEN_CONT, PS_STRING, PS_DRAIN
	} parse_phase_t;

	typedef enum int {INT_DONE, INT_MORE, INT_OVERFLOW} int_step_t;

	typedef enum int {SINK_STEADY, SINK_LIGHT, SINK_HEAVY} sink_mode_t;

	// Field shapes for the random block builder; the last three may be malformed on purpose.
	typedef enum int {
		FK_INDEXED, FK_INCREMENTAL, FK_WITHOUT, FK_NEVER, FK_SIZE,
		FK_PADDED, FK_NOISE, FK_OPEN_STRING
	} field_kind_t;

	typedef struct packed {
		event_t               ev;
		rep_t                 rep;
		logic [NUM_W-1:0]     num;
		logic [OCTET_W-1:0]   oct;
		logic                 huf;
		logic                 done;
		err_t                 err;
	} event_rec_t;

	logic clk;
	logic arst_n;

	hpack_octet_if ingress();
	hpack_event_if egress();

	hpack_header_block_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.ingress(ingress),
		.egress (egress)
	);

	// Predictor state, mirrors the parse state of the block.
	parse_phase_t ps         = PS_REP;
	rep_t         cur_rep    = REP_INDEXED;
	logic [31:0]  acc        = '0;
	int           shift_bits = 0;
	int           cont_count = 0;
	logic         huff_cur   = 1'b0;
	logic [31:0]  str_left   = '0;
	logic         in_val     = 1'b0;
	event_rec_t   nxt;

	// Events the parser still owes us, oldest first.
	event_rec_t   decoded_events[$];
	event_rec_t   want;
	int           failures      = 0;
	int           parsed_octets = 0;

	// Sender and receiver pacing.
	int           burst_left;
	sink_mode_t   sink_mode  = SINK_STEADY;
	int           mode_left  = 0;
	int           stall_left = 0;

	logic [7:0]   block_octets[$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("[hpack_header_block_parser] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void go_idle();
		ps         = PS_REP;
		acc        = '0;
		shift_bits = 0;
		cont_count = 0;
		huff_cur   = 1'b0;
		str_left   = '0;
		in_val     = 1'b0;
	endfunction

	// Load the prefix bits; report whether the integer is already complete.
	function automatic logic int_begin(input logic [31:0] v, input int bits);
		logic [31:0] full;
		full       = (32'd1 << bits) - 32'd1;
		acc        = v;
		shift_bits = 0;
		cont_count = 0;
		return v < full;
	endfunction

	function automatic int_step_t int_more(input logic [7:0] b);
		logic [63:0] part;
		logic [63:0] sum;
		if (cont_count + 2 > HPACK_INT_OCTET_LIMIT || shift_bits > 56)
			return INT_OVERFLOW;
		part = {57'd0, b[6:0]};
		sum  = {32'd0, acc} + (part << shift_bits);
		if (sum > 64'hFFFF_FFFF)
			return INT_OVERFLOW;
		acc        = sum[31:0];
		shift_bits = shift_bits + 7;
		cont_count = cont_count + 1;
		return b[7] ? INT_MORE : INT_DONE;
	endfunction

	function automatic void index_complete();
		if (cur_rep == REP_INDEXED) begin
			if (acc == 0) begin
				nxt.err = ERR_INDEX_ZERO;
				return;
			end
			nxt.ev   = EV_INDEXED;
			nxt.num  = acc;
			nxt.done = 1'b1;
			go_idle();
			return;
		end
		// A zero name index means a literal name follows: nothing to report yet.
		if (acc != 0) begin
			nxt.ev  = EV_NAME_INDEX;
			nxt.num = acc;
		end
		in_val = 1'b0;
		ps     = PS_LEN_FIRST;
	endfunction

	function automatic void size_complete();
		nxt.ev   = EV_SIZE_UPDATE;
		nxt.num  = acc;
		nxt.done = 1'b1;
		go_idle();
	endfunction

	function automatic void length_complete();
		nxt.ev  = in_val ? EV_VALUE_LEN : EV_NAME_LENGTH;
		nxt.num = acc;
		nxt.huf = huff_cur;
		if (acc == 0) begin
			if (in_val) begin
				nxt.done = 1'b1;
				go_idle();
			end else begin
				in_val = 1'b1;
				ps     = PS_LEN_FIRST;
			end
		end else begin
			str_left = acc;
			ps       = PS_STRING;
		end
	endfunction

	// Work out the one event that an accepted octet causes, and advance the state.
	function automatic event_rec_t decode_octet(input logic [7:0] b, input logic last);
		int_step_t step;
		nxt = '0;
		case (ps)
			PS_REP: begin
				huff_cur = 1'b0;
				in_val   = 1'b0;
				if (b[7]) begin
					cur_rep = REP_INDEXED;
					if (int_begin(b[6:0], 7)) index_complete(); else ps = PS_IDX_CONT;
				end else if (b[6]) begin
					cur_rep = REP_INCREMENTAL;
					if (int_begin(b[5:0], 6)) index_complete(); else ps = PS_IDX_CONT;
				end else if (b[5]) begin
					cur_rep = REP_INDEXED;
					if (int_begin(b[4:0], 5)) size_complete(); else ps = PS_SIZE_CONT;
				end else begin
					cur_rep = b[4] ? REP_NEVER_IDX : REP_WITHOUT_IDX;
					if (int_begin(b[3:0], 4)) index_complete(); else ps = PS_IDX_CONT;
				end
			end
			PS_IDX_CONT: begin
				step = int_more(b);
				if (step == INT_OVERFLOW) nxt.err = ERR_OVERFLOW;
				else if (step == INT_DONE) index_complete();
			end
			PS_SIZE_CONT: begin
				step = int_more(b);
				if (step == INT_OVERFLOW) nxt.err = ERR_OVERFLOW;
				else if (step == INT_DONE) size_complete();
			end
			PS_LEN_FIRST: begin
				huff_cur = b[7];
				if (int_begin(b[6:0], 7)) length_complete(); else ps = PS_LEN_CONT;
			end
			PS_LEN_CONT: begin
				step = int_more(b);
				if (step == INT_OVERFLOW) nxt.err = ERR_OVERFLOW;
				else if (step == INT_DONE) length_complete();
			end
			PS_STRING: begin
				nxt.ev   = in_val ? EV_VALUE_OCTET : EV_NAME_OCTET;
				nxt.oct  = b;
				nxt.huf  = huff_cur;
				str_left = str_left - 1;
				if (str_left == 0) begin
					if (in_val) begin
						nxt.done = 1'b1;
						go_idle();
					end else begin
						in_val = 1'b1;
						ps     = PS_LEN_FIRST;
					end
				end
			end
			PS_DRAIN: begin
				if (last) go_idle();
			end
			default: go_idle();
		endcase

		nxt.rep = (nxt.ev == EV_SIZE_UPDATE) ? REP_INDEXED : cur_rep;

		// An error found by the octet itself wins over the truncation error.
		if (nxt.err == ERR_NONE && last && ps != PS_REP)
			nxt.err = ERR_TRUNCATED;

		if (nxt.err != ERR_NONE) begin
			nxt.ev   = EV_ERROR;
			nxt.num  = '0;
			nxt.oct  = '0;
			nxt.huf  = 1'b0;
			nxt.done = 1'b0;
			go_idle();
			if (!last) ps = PS_DRAIN;
		end
		return nxt;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: predict on every ingress transfer, check every egress transfer
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			if (failures < 100)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, name, want_v, got_v);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			// Predict first so a same-edge result could never overtake its octet.
			if (ingress.valid && ingress.ready) begin
				if (ps != PS_DRAIN) parsed_octets++;
				decoded_events.push_back(decode_octet(ingress.octet, ingress.block_end));
			end
			if (egress.valid && egress.ready) begin
				if (decoded_events.size() == 0) begin
					if (failures < 100)
						$display("%0t ns: unexpected event transfer, event_res %0d",
							$time, egress.event_res);
					failures++;
				end else begin
					want = decoded_events.pop_front();
					check_field("event_res", want.ev, egress.event_res);
					check_field("representation", want.rep, egress.representation);
					check_field("number", want.num, egress.number);
					check_field("octet_out", want.oct, egress.octet_out);
					check_field("huffman", want.huf, egress.huffman);
					check_field("field_done", want.done, egress.field_done);
					check_field("error_code", want.err, egress.error_code);
				end
			end
		end
	end

	// Egress backpressure: modes switch at random intervals, and the steady mode
	// leaves long stretches with ready held high.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(SINK_STEADY, SINK_HEAVY));
			mode_left = $urandom_range(50, 400);
		end else begin
			mode_left--;
		end
		if (stall_left > 0) begin
			egress.ready <= 1'b0;
			stall_left--;
		end else begin
			egress.ready <= 1'b1;
			case (sink_mode)
				SINK_LIGHT: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 3);
				SINK_HEAVY: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 8);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Send one octet; between bursts hold valid low for a random gap.
	task automatic send_octet(input logic [7:0] b, input logic last);
		if (burst_left == 0) begin
			ingress.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 12);
		end
		ingress.valid     <= 1'b1;
		ingress.octet     <= b;
		ingress.block_end <= last;
		@(posedge clk);
		while (!ingress.ready) @(posedge clk);
		burst_left--;
	endtask

	// Hold the sender until every predicted event has come back.
	task automatic wait_drained();
		ingress.valid <= 1'b0;
		@(posedge clk);
		while (decoded_events.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic send_block();
		foreach (block_octets[i])
			send_octet(block_octets[i], i == block_octets.size() - 1);
	endtask

	// Mostly small numbers, sometimes wide ones that can need every continuation octet.
	function automatic logic [31:0] rand_num();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 20);
			6, 7:             return $urandom_range(0, 300);
			default:          return $urandom & ((32'd1 << $urandom_range(1, 28)) - 32'd1);
		endcase
	endfunction

	function automatic int rand_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
	endfunction

	// Append a prefixed integer: flag bits above a prefix of the given width.
	function automatic void put_int(input logic [7:0] flags, input int bits,
			input logic [31:0] value);
		logic [31:0] full;
		logic [31:0] rest;
		full = (32'd1 << bits) - 32'd1;
		if (value < full) begin
			block_octets.push_back(flags | value[7:0]);
		end else begin
			block_octets.push_back(flags | full[7:0]);
			rest = value - full;
			while (rest >= 128) begin
				block_octets.push_back({1'b1, rest[6:0]});
				rest = rest >> 7;
			end
			block_octets.push_back({1'b0, rest[6:0]});
		end
	endfunction

	function automatic void put_string(input int len);
		put_int($urandom_range(0, 1) ? 8'h80 : 8'h00, 7, len);
		repeat (len) block_octets.push_back($urandom_range(0, 255));
	endfunction

	// A literal is always followed by a name string and a value string here.
	function automatic void put_literal(input logic [7:0] flags, input int bits);
		put_int(flags, bits, ($urandom_range(0, 2) == 0) ? 32'd0 : rand_num());
		put_string(rand_len());
		put_string(rand_len());
	endfunction

	function automatic void build_block();
		field_kind_t kind;
		int          n_fields;
		logic        stop;
		int          keep;
		block_octets.delete();
		n_fields = $urandom_range(1, 6);
		stop     = 1'b0;
		for (int f = 0; f < n_fields && !stop; f++) begin
			kind = field_kind_t'($urandom_range(FK_INDEXED, FK_SIZE));
			if ($urandom_range(0, 9) == 0)
				kind = field_kind_t'($urandom_range(FK_PADDED, FK_OPEN_STRING));
			case (kind)
				FK_INDEXED: begin
					keep = rand_num();
					if (keep == 0 && $urandom_range(0, 3) != 0) keep = 1;
					put_int(8'h80, 7, keep);
				end
				FK_INCREMENTAL: put_literal(8'h40, 6);
				FK_WITHOUT:     put_literal(8'h00, 4);
				FK_NEVER:       put_literal(8'h10, 4);
				FK_SIZE:        put_int(8'h20, 5, rand_num());
				FK_PADDED: begin
					// Redundant continuation octets: fine up to the octet limit, then overflow.
					block_octets.push_back(8'hFF);
					repeat ($urandom_range(1, 6)) block_octets.push_back(8'h80);
					block_octets.push_back(8'h00);
				end
				FK_NOISE: repeat ($urandom_range(1, 4))
					block_octets.push_back($urandom_range(0, 255));
				default: begin
					// Long value announced, block ends inside it.
					put_int(8'h40, 6, rand_num());
					put_string(rand_len());
					put_int($urandom_range(0, 1) ? 8'h80 : 8'h00, 7, 32'd64 + rand_num());
					repeat ($urandom_range(0, 5)) block_octets.push_back($urandom_range(0, 255));
					stop = 1'b1;
				end
			endcase
		end
		// Now and then cut the block short at a random octet.
		if ($urandom_range(0, 9) == 0) begin
			keep = $urandom_range(1, block_octets.size());
			while (block_octets.size() > keep) void'(block_octets.pop_back());
		end
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every representation, empty strings, multi-octet integers, size updates.
	task automatic test_field_kinds();
		send_octet(8'h20, 1'b0);   // size update to zero
		send_octet(8'h81, 1'b0);   // indexed, index 1
		send_octet(8'h40, 1'b0);   // incremental, literal name
		send_octet(8'h80, 1'b0);   // empty Huffman name
		send_octet(8'h00, 1'b0);   // empty value ends the field
		send_octet(8'h12, 1'b0);   // never indexed, name index 2
		send_octet(8'h81, 1'b0);   // one-octet Huffman name
		send_octet(8'hFF, 1'b0);
		send_octet(8'h00, 1'b0);   // empty value
		send_octet(8'h3F, 1'b0);   // size update over three octets
		send_octet(8'hE1, 1'b0);
		send_octet(8'h1F, 1'b0);
		send_octet(8'h0F, 1'b0);   // without indexing, three-octet name index
		send_octet(8'h80, 1'b0);
		send_octet(8'h01, 1'b0);
		send_octet(8'h01, 1'b0);
		send_octet(8'hA5, 1'b0);
		send_octet(8'h01, 1'b0);
		send_octet(8'h00, 1'b1);   // last value octet closes both field and block
		wait_drained();
	endtask

	task automatic test_error_paths();
		// Index zero, then drain the rest of the block.
		send_octet(8'h80, 1'b0);
		send_octet(8'hAA, 1'b0);
		send_octet(8'h55, 1'b1);
		// Integer one octet past the limit, overflow found on the block end octet.
		send_octet(8'hFF, 1'b0);
		repeat (4) send_octet(8'hFF, 1'b0);
		send_octet(8'hFF, 1'b1);
		// Block ends right after a name index.
		send_octet(8'h44, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_blocks();
		int target;
		int n_blocks;
		target   = parsed_octets + 1500;
		n_blocks = 0;
		while (parsed_octets < target) begin
			build_block();
			send_block();
			n_blocks++;
			if (n_blocks % 8 == 0) wait_drained();
		end
	endtask

	initial begin
		ingress.valid     <= 1'b0;
		ingress.octet     <= '0;
		ingress.block_end <= 1'b0;
		arst_n            <= 1'b0;
		burst_left    = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_kinds();
		test_error_paths();
		test_random_blocks();

		// Drop valid, let the last events out, then let the block sit idle before the verdict.
		wait_drained();
		repeat (8) @(posedge clk);

		if (failures == 0)
			$display("[hpack_header_block_parser] OK");
		else
			$display("[hpack_header_block_parser] ERROR");
		$finish;
	end

endmodule
